FILE: rtl/text_terminal_escape_parser_macros.svh
// ----------------------------------------------------------------------------
// text_terminal_escape_parser_macros.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_ESCAPE_PARSER_MACROS_SVH
`define TEXT_TERMINAL_ESCAPE_PARSER_MACROS_SVH

// same-cycle implication, disabled in reset
`define TEP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tep assertion failed");

// next-cycle implication, disabled in reset
`define TEP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tep assertion failed");

`endif

FILE: rtl/tep_pkg.sv
// ----------------------------------------------------------------------------
// tep_pkg
// shared types, codes and helpers of the terminal escape parser
// ----------------------------------------------------------------------------
package tep_pkg;

   localparam int ARG_COUNT_DEF = 2;

   // reset values of the configuration registers
   localparam logic [7:0]  ROWS_RST = 8'd25;
   localparam logic [7:0]  COLS_RST = 8'd80;
   localparam logic [15:0] DEF_ATTR_RST = 16'd0;
   localparam logic [15:0] REV_ATTR_RST = 16'd1;
   localparam logic [15:0] KERN_ATTR_RST = 16'd0;

   // configuration register indexes
   localparam logic [2:0] IDX_ROWS = 3'd0;
   localparam logic [2:0] IDX_COLS = 3'd1;
   localparam logic [2:0] IDX_DEF_ATTR = 3'd2;
   localparam logic [2:0] IDX_REV_ATTR = 3'd3;
   localparam logic [2:0] IDX_KERN_ATTR = 3'd4;

   // result operations
   localparam logic [2:0] OP_PUT = 3'd0;
   localparam logic [2:0] OP_ECOLS = 3'd1;
   localparam logic [2:0] OP_EROWS = 3'd2;
   localparam logic [2:0] OP_CCOLS = 3'd3;
   localparam logic [2:0] OP_CROWS = 3'd4;
   localparam logic [2:0] OP_BELL = 3'd5;
   localparam logic [2:0] OP_CURSOR = 3'd6;

   // characters
   localparam logic [7:0] CH_BEL = 8'd7;
   localparam logic [7:0] CH_BS = 8'd8;
   localparam logic [7:0] CH_HT = 8'd9;
   localparam logic [7:0] CH_LF = 8'd10;
   localparam logic [7:0] CH_VT = 8'd11;
   localparam logic [7:0] CH_FF = 8'd12;
   localparam logic [7:0] CH_CR = 8'd13;
   localparam logic [7:0] CH_ESC = 8'd27;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_ICH = 8'h40;
   localparam logic [7:0] CH_CUU = 8'h41;
   localparam logic [7:0] CH_CUD = 8'h42;
   localparam logic [7:0] CH_CUF = 8'h43;
   localparam logic [7:0] CH_CUB = 8'h44;
   localparam logic [7:0] CH_CNL = 8'h45;
   localparam logic [7:0] CH_CUP = 8'h48;
   localparam logic [7:0] CH_ED = 8'h4A;
   localparam logic [7:0] CH_EL = 8'h4B;
   localparam logic [7:0] CH_IL = 8'h4C;
   localparam logic [7:0] CH_DL = 8'h4D;
   localparam logic [7:0] CH_DCH = 8'h50;
   localparam logic [7:0] CH_HVP = 8'h66;
   localparam logic [7:0] CH_SGR = 8'h6D;
   localparam logic [7:0] CH_BOW = 8'h70;
   localparam logic [7:0] CH_WOB = 8'h71;
   localparam logic [7:0] CH_SCROLL = 8'h72;
   localparam logic [7:0] CH_RESET = 8'h73;

   // rendition flag bits
   localparam int FLAG_INVERT = 0;
   localparam int FLAG_STANDOUT = 1;

   typedef enum logic [3:0] {
      CL_BELL, CL_BS, CL_CR, CL_HT, CL_FF, CL_VT, CL_LF, CL_ESC,
      CL_DIGIT, CL_SEMI, CL_LBRACK, CL_OTHER
   } cls_type;

   typedef enum logic [1:0] {ST_NORMAL, ST_ESC, ST_CSI} pstate_type;

   typedef enum logic [1:0] {PH_MAIN, PH_LF, PH_HOLD, PH_CURSOR} phase_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       kern;
      cls_type    cls;
   } entry_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  row;
      logic [7:0]  col;
      logic [7:0]  src;
      logic [7:0]  dst;
      logic [7:0]  span;
      logic [7:0]  ch;
      logic [15:0] attr;
   } cmd_type;

   function automatic cmd_type mk_cmd(input logic [2:0] op, input logic [7:0] row,
                                      input logic [7:0] col, input logic [7:0] src,
                                      input logic [7:0] dst, input logic [7:0] span,
                                      input logic [7:0] ch, input logic [15:0] attr);
      cmd_type c;
      c.op = op;
      c.row = row;
      c.col = col;
      c.src = src;
      c.dst = dst;
      c.span = span;
      c.ch = ch;
      c.attr = attr;
      return c;
   endfunction

endpackage

FILE: rtl/text_terminal_escape_parser.sv
// ----------------------------------------------------------------------------
// text_terminal_escape_parser
// console byte parser that turns a character stream into drawing commands
// ----------------------------------------------------------------------------
// throughput: one word per cycle while the receiver takes them; the sequencer steps
// a byte through its main, line-feed, held-word and cursor phases as the byte needs
// them, and starts the next byte only once the cursor report of the last one is issued
// reset: synchronous, clears queue, parse state, cursor and output; geometry and
// attribute registers return to their defaults, scroll distance to one
module text_terminal_escape_parser #(
   parameter int ARG_COUNT = tep_pkg::ARG_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   input  logic        req_kernel_output,
   // command output
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_operation,
   output logic [7:0]  rsp_row_index,
   output logic [7:0]  rsp_col_index,
   output logic [7:0]  rsp_source_index,
   output logic [7:0]  rsp_dest_index,
   output logic [7:0]  rsp_span_length,
   output logic [7:0]  rsp_char_code,
   output logic [15:0] rsp_attr_code,
   output logic [7:0]  rsp_cursor_row,
   output logic [7:0]  rsp_cursor_col,
   output logic        rsp_last,
   // register write port
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   // queue head between the classifier and the sequencer
   logic               head_valid;
   logic               head_pop;
   tep_pkg::entry_type head;
   tep_pkg::cmd_type   cmd;

   // front: classify each byte and buffer up to two of them
   tep_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_byte_in       (req_byte_in),
      .req_kernel_output (req_kernel_output),
      .head_valid        (head_valid),
      .head              (head),
      .head_pop          (head_pop)
   );

   // back: parse state, cursor and command words
   tep_exec #(.ARG_COUNT(ARG_COUNT)) u_exec (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .head_valid     (head_valid),
      .head           (head),
      .head_pop       (head_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cmd        (cmd),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_last       (rsp_last)
   );

   // unpack the command word onto its field ports
   assign rsp_operation = cmd.op;
   assign rsp_row_index = cmd.row;
   assign rsp_col_index = cmd.col;
   assign rsp_source_index = cmd.src;
   assign rsp_dest_index = cmd.dst;
   assign rsp_span_length = cmd.span;
   assign rsp_char_code = cmd.ch;
   assign rsp_attr_code = cmd.attr;

endmodule

FILE: rtl/tep_front.sv
// ----------------------------------------------------------------------------
// tep_front
// classifies incoming bytes and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module tep_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_byte_in,
   input  logic                req_kernel_output,
   output logic                head_valid,
   output tep_pkg::entry_type  head,
   input  logic                head_pop
);

   tep_pkg::entry_type q_ff [2];
   tep_pkg::entry_type entry;
   tep_pkg::cls_type   cls;
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               push;

   // byte class
   always_comb begin
      case (req_byte_in)
         tep_pkg::CH_BEL:    cls = tep_pkg::CL_BELL;
         tep_pkg::CH_BS:     cls = tep_pkg::CL_BS;
         tep_pkg::CH_CR:     cls = tep_pkg::CL_CR;
         tep_pkg::CH_HT:     cls = tep_pkg::CL_HT;
         tep_pkg::CH_FF:     cls = tep_pkg::CL_FF;
         tep_pkg::CH_VT:     cls = tep_pkg::CL_VT;
         tep_pkg::CH_LF:     cls = tep_pkg::CL_LF;
         tep_pkg::CH_ESC:    cls = tep_pkg::CL_ESC;
         tep_pkg::CH_SEMI:   cls = tep_pkg::CL_SEMI;
         tep_pkg::CH_LBRACK: cls = tep_pkg::CL_LBRACK;
         default: begin
            if (req_byte_in inside {[tep_pkg::CH_ZERO:tep_pkg::CH_NINE]}) begin
               cls = tep_pkg::CL_DIGIT;
            end else begin
               cls = tep_pkg::CL_OTHER;
            end
         end
      endcase
   end

   assign entry = '{ch: req_byte_in, kern: req_kernel_output, cls: cls};
   assign req_ready = (cnt_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign head_valid = (cnt_ff != 2'd0);
   assign head = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, head_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

FILE: rtl/tep_exec.sv
// ----------------------------------------------------------------------------
// tep_exec
// parse state, cursor and command sequencer, one result word per cycle while the output is not stalled
// ----------------------------------------------------------------------------
module tep_exec #(
   parameter int ARG_COUNT = tep_pkg::ARG_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_data,
   input  logic                head_valid,
   input  tep_pkg::entry_type  head,
   output logic                head_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tep_pkg::cmd_type    rsp_cmd,
   output logic [7:0]          rsp_cursor_row,
   output logic [7:0]          rsp_cursor_col,
   output logic                rsp_last
);

   function automatic logic [7:0] min_arg(input logic [15:0] a, input logic [7:0] b);
      return (a < {8'd0, b}) ? a[7:0] : b;
   endfunction

   logic [7:0]  rows_ff, cols_ff;
   logic [15:0] def_ff, rev_ff, katt_ff;

   tep_pkg::pstate_type pstate_ff, pstate_in;
   tep_pkg::phase_type  phase_ff, phase_in;
   logic [15:0] args_ff [ARG_COUNT];
   logic [15:0] args_in [ARG_COUNT];
   logic [7:0]  row_ff, row_in, col_ff, col_in, sd_ff, sd_in;
   logic [1:0]  flags_ff, flags_in;
   logic        second_ff, second_in;
   tep_pkg::cmd_type hold_ff, hold_cmd;
   logic        hold_ld;

   logic        out_valid_ff, out_valid_in;
   tep_pkg::cmd_type out_cmd_ff;
   logic [7:0]  out_crow_ff, out_ccol_ff;
   logic        out_last_ff;

   logic [7:0]  rr, cc_n, rc, cc, c_lim, r_lim, ncol, nrow, tab_step, tab_lim, tabn, dd;
   logic [15:0] cur_attr, attr_n, a0, a1, n0, n1;
   logic [19:0] acc;
   logic        adv, emit, emit_cur, need_lf, do_norm, do_print, csi_ctl;
   logic        two_cmd, have_first;
   tep_pkg::cmd_type emit_cmd, first_cmd, second_cmd;
   tep_pkg::cls_type ncls;
   logic [7:0]  nch;

   assign csr_ready = 1'b1;
   assign rr = (rows_ff == 8'd0) ? 8'd1 : rows_ff;
   assign cc_n = (cols_ff == 8'd0) ? 8'd1 : cols_ff;
   assign rc = (row_ff >= rr) ? rr - 8'd1 : row_ff;
   assign cc = (col_ff >= cc_n) ? cc_n - 8'd1 : col_ff;
   assign c_lim = cc_n - cc;
   assign r_lim = rr - rc;
   assign cur_attr = (flags_ff[tep_pkg::FLAG_INVERT] ^ flags_ff[tep_pkg::FLAG_STANDOUT])
                     ? rev_ff : def_ff;
   assign attr_n = head.kern ? katt_ff : cur_attr;
   assign a0 = args_ff[0];
   assign a1 = args_ff[1];
   assign n0 = (a0 == 16'd0) ? 16'd1 : a0;
   assign n1 = (a1 == 16'd0) ? 16'd1 : a1;
   assign ncol = min_arg(n0, c_lim);
   assign nrow = min_arg(n0, r_lim);
   assign tab_step = 8'd8 - {5'd0, cc[2:0]};
   assign tab_lim = c_lim - 8'd1;
   assign tabn = (tab_step < tab_lim) ? tab_step : tab_lim;
   assign dd = (sd_ff < rr) ? sd_ff : rr;
   assign acc = ({4'd0, a0} << 3) + ({4'd0, a0} << 1) + {16'd0, head.ch[3:0]};
   assign adv = !out_valid_ff || rsp_ready;

   // datapath of each phase
   always_comb begin
      emit = 1'b0;
      emit_cur = 1'b0;
      emit_cmd = '0;
      hold_ld = 1'b0;
      hold_cmd = '0;
      need_lf = 1'b0;
      do_norm = 1'b0;
      do_print = 1'b0;
      csi_ctl = 1'b0;
      two_cmd = 1'b0;
      have_first = 1'b0;
      first_cmd = '0;
      second_cmd = '0;
      nch = head.ch;
      ncls = head.cls;
      row_in = row_ff;
      col_in = col_ff;
      pstate_in = pstate_ff;
      second_in = second_ff;
      args_in = args_ff;
      sd_in = sd_ff;
      flags_in = flags_ff;
      head_pop = 1'b0;
      case (phase_ff)
         tep_pkg::PH_MAIN: begin
            if (head_valid && adv) begin
               row_in = rc;
               col_in = cc;
               if (head.kern) begin
                  do_norm = 1'b1;
               end else if (second_ff) begin
                  do_norm = 1'b1;
                  pstate_in = tep_pkg::ST_NORMAL;
                  second_in = 1'b0;
               end else begin
                  case (pstate_ff)
                     tep_pkg::ST_ESC: begin
                        if (head.cls == tep_pkg::CL_LBRACK) begin
                           for (int i = 0; i < ARG_COUNT; i++) args_in[i] = 16'd0;
                           pstate_in = tep_pkg::ST_CSI;
                        end else begin
                           // the escape byte itself is drawn first
                           do_norm = 1'b1;
                           nch = tep_pkg::CH_ESC;
                           ncls = tep_pkg::CL_ESC;
                           second_in = 1'b1;
                        end
                     end
                     tep_pkg::ST_CSI: begin
                        if (head.cls == tep_pkg::CL_DIGIT) begin
                           args_in[0] = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];
                        end else if (head.cls == tep_pkg::CL_SEMI) begin
                           for (int i = 1; i < ARG_COUNT; i++) args_in[i] = args_ff[i-1];
                           args_in[0] = 16'd0;
                        end else begin
                           csi_ctl = 1'b1;
                           pstate_in = tep_pkg::ST_NORMAL;
                        end
                     end
                     default: do_norm = 1'b1;
                  endcase
               end
            end
         end
         tep_pkg::PH_LF: begin
            if (adv) begin
               if (row_ff < rr - 8'd1) begin
                  row_in = row_ff + 8'd1;
               end else if (sd_ff == 8'd0) begin
                  row_in = 8'd0;
                  emit = 1'b1;
                  emit_cmd = tep_pkg::mk_cmd(tep_pkg::OP_EROWS, 8'd0, 8'd0, 8'd0, 8'd0,
                                             8'd1, 8'd0, cur_attr);
               end else begin
                  emit = 1'b1;
                  emit_cmd = tep_pkg::mk_cmd(tep_pkg::OP_CROWS, 8'd0, 8'd0, dd, 8'd0,
                                             rr - dd, 8'd0, 16'd0);
                  hold_ld = 1'b1;
                  hold_cmd = tep_pkg::mk_cmd(tep_pkg::OP_EROWS, rr - dd, 8'd0, 8'd0, 8'd0,
                                             dd, 8'd0, cur_attr);
                  row_in = rr - dd;
               end
            end
         end
         tep_pkg::PH_HOLD: begin
            if (adv) begin
               emit = 1'b1;
               emit_cmd = hold_ff;
            end
         end
         tep_pkg::PH_CURSOR: begin
            if (adv) begin
               emit = 1'b1;
               emit_cur = 1'b1;
               emit_cmd = tep_pkg::mk_cmd(tep_pkg::OP_CURSOR, 8'd0, 8'd0, 8'd0, 8'd0,
                                          8'd0, 8'd0, 16'd0);
               head_pop = 1'b1;
            end
         end
         default: ;
      endcase

      // normal-state character handling
      if (do_norm) begin
         case (ncls)
            tep_pkg::CL_BELL: begin
               emit = 1'b1;
               emit_cmd = tep_pkg::mk_cmd(tep_pkg::OP_BELL, 8'd0, 8'd0, 8'd0, 8'd0,
                                          8'd0, 8'd0, 16'd0);
            end
            tep_pkg::CL_BS: if (cc != 8'd0) col_in = cc - 8'd1;
            tep_pkg::CL_CR: col_in = 8'd0;
            tep_pkg::CL_HT: begin
               emit = 1'b1;
               emit_cmd = tep_pkg::mk_cmd(tep_pkg::OP_ECOLS, rc, cc, 8'd0, 8'd0,
                                          tabn, 8'd0, attr_n);
               col_in = cc + tabn;
            end
            tep_pkg::CL_FF: begin
               emit = 1'b1;
               emit_cmd = tep_pkg::mk_cmd(tep_pkg::OP_EROWS, 8'd0, 8'd0, 8'd0, 8'd0,
                                          rr, 8'd0, attr_n);
               row_in = 8'd0;
               col_in = 8'd0;
            end
            tep_pkg::CL_VT: if (rc != 8'd0) row_in = rc - 8'd1;
            tep_pkg::CL_LF: need_lf = 1'b1;
            tep_pkg::CL_ESC: begin
               if (head.kern) begin
                  // kernel output drops escapes
               end else if (pstate_ff == tep_pkg::ST_NORMAL) begin
                  pstate_in = tep_pkg::ST_ESC;
               end else begin
                  do_print = 1'b1;
               end
            end
            default: do_print = 1'b1;
         endcase
         if (do_print) begin
            emit = 1'b1;
            emit_cmd = tep_pkg::mk_cmd(tep_pkg::OP_PUT, rc, cc, 8'd0, 8'd0, 8'd0, nch, attr_n);
            if (cc < cc_n - 8'd1) begin
               col_in = cc + 8'd1;
            end else begin
               col_in = 8'd0;
               need_lf = 1'b1;
            end
         end
      end

      // control sequence final byte
      if (csi_ctl) begin
         case (head.ch)
            tep_pkg::CH_ICH: begin
               two_cmd = 1'b1;
               have_first = ncol < c_lim;
               first_cmd = tep_pkg::mk_cmd(tep_pkg::OP_CCOLS, rc, 8'd0, cc, cc + ncol,
                                           c_lim - ncol, 8'd0, 16'd0);
               second_cmd = tep_pkg::mk_cmd(tep_pkg::OP_ECOLS, rc, cc, 8'd0, 8'd0,
                                            ncol, 8'd0, cur_attr);
            end
            tep_pkg::CH_DCH: begin
               two_cmd = 1'b1;
               have_first = ncol < c_lim;
               first_cmd = tep_pkg::mk_cmd(tep_pkg::OP_CCOLS, rc, 8'd0, cc + ncol, cc,
                                           c_lim - ncol, 8'd0, 16'd0);
               second_cmd = tep_pkg::mk_cmd(tep_pkg::OP_ECOLS, rc, cc_n - ncol, 8'd0, 8'd0,
                                            ncol, 8'd0, cur_attr);
            end
            tep_pkg::CH_IL: begin
               two_cmd = 1'b1;
               have_first = nrow < r_lim;
               first_cmd = tep_pkg::mk_cmd(tep_pkg::OP_CROWS, 8'd0, 8'd0, rc, rc + nrow,
                                           r_lim - nrow, 8'd0, 16'd0);
               second_cmd = tep_pkg::mk_cmd(tep_pkg::OP_EROWS, rc, 8'd0, 8'd0, 8'd0,
                                            nrow, 8'd0, cur_attr);
            end
            tep_pkg::CH_DL: begin
               two_cmd = 1'b1;
               have_first = nrow < r_lim;
               first_cmd = tep_pkg::mk_cmd(tep_pkg::OP_CROWS, 8'd0, 8'd0, rc + nrow, rc,
                                           r_lim - nrow, 8'd0, 16'd0);
               second_cmd = tep_pkg::mk_cmd(tep_pkg::OP_EROWS, rr - nrow, 8'd0, 8'd0, 8'd0,
                                            nrow, 8'd0, cur_attr);
            end
            tep_pkg::CH_ED: begin
               two_cmd = 1'b1;
               have_first = r_lim > 8'd1;
               first_cmd = tep_pkg::mk_cmd(tep_pkg::OP_EROWS, rc + 8'd1, 8'd0, 8'd0, 8'd0,
                                           r_lim - 8'd1, 8'd0, cur_attr);
               second_cmd = tep_pkg::mk_cmd(tep_pkg::OP_ECOLS, rc, cc, 8'd0, 8'd0,
                                            c_lim, 8'd0, cur_attr);
            end
            tep_pkg::CH_EL: begin
               two_cmd = 1'b1;
               second_cmd = tep_pkg::mk_cmd(tep_pkg::OP_ECOLS, rc, cc, 8'd0, 8'd0,
                                            c_lim, 8'd0, cur_attr);
            end
            tep_pkg::CH_CUU: row_in = rc - min_arg(n0, rc);
            tep_pkg::CH_CNL: begin
               col_in = 8'd0;
               row_in = rc + min_arg(n0, r_lim - 8'd1);
            end
            tep_pkg::CH_CUD: row_in = rc + min_arg(n0, r_lim - 8'd1);
            tep_pkg::CH_CUF: col_in = cc + min_arg(n0, c_lim - 8'd1);
            tep_pkg::CH_CUB: col_in = cc - min_arg(n0, cc);
            tep_pkg::CH_CUP, tep_pkg::CH_HVP: begin
               row_in = min_arg(n1, rr) - 8'd1;
               col_in = min_arg(n0, cc_n) - 8'd1;
            end
            tep_pkg::CH_SGR: flags_in[tep_pkg::FLAG_STANDOUT] = (a0 != 16'd0);
            tep_pkg::CH_BOW: flags_in[tep_pkg::FLAG_INVERT] = 1'b1;
            tep_pkg::CH_WOB: flags_in[tep_pkg::FLAG_INVERT] = 1'b0;
            tep_pkg::CH_SCROLL: sd_in = min_arg(a0, rr);
            tep_pkg::CH_RESET: begin
               sd_in = 8'd1;
               flags_in = 2'b00;
            end
            default: ;
         endcase
         if (two_cmd) begin
            emit = 1'b1;
            if (have_first) begin
               emit_cmd = first_cmd;
               hold_ld = 1'b1;
               hold_cmd = second_cmd;
            end else begin
               emit_cmd = second_cmd;
            end
         end
      end
   end

   // phase sequencing
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         tep_pkg::PH_MAIN: begin
            if (head_valid && adv) begin
               if (need_lf) phase_in = tep_pkg::PH_LF;
               else if (hold_ld) phase_in = tep_pkg::PH_HOLD;
               else if (second_in) phase_in = tep_pkg::PH_MAIN;
               else phase_in = tep_pkg::PH_CURSOR;
            end
         end
         tep_pkg::PH_LF: begin
            if (adv) begin
               if (hold_ld) phase_in = tep_pkg::PH_HOLD;
               else if (second_ff) phase_in = tep_pkg::PH_MAIN;
               else phase_in = tep_pkg::PH_CURSOR;
            end
         end
         tep_pkg::PH_HOLD: begin
            if (adv) phase_in = second_ff ? tep_pkg::PH_MAIN : tep_pkg::PH_CURSOR;
         end
         tep_pkg::PH_CURSOR: begin
            if (adv) phase_in = tep_pkg::PH_MAIN;
         end
         default: phase_in = tep_pkg::PH_MAIN;
      endcase
   end

   assign out_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= tep_pkg::ROWS_RST;
         cols_ff <= tep_pkg::COLS_RST;
         def_ff <= tep_pkg::DEF_ATTR_RST;
         rev_ff <= tep_pkg::REV_ATTR_RST;
         katt_ff <= tep_pkg::KERN_ATTR_RST;
         pstate_ff <= tep_pkg::ST_NORMAL;
         phase_ff <= tep_pkg::PH_MAIN;
         for (int i = 0; i < ARG_COUNT; i++) args_ff[i] <= 16'd0;
         row_ff <= 8'd0;
         col_ff <= 8'd0;
         sd_ff <= 8'd1;
         flags_ff <= 2'b00;
         second_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               tep_pkg::IDX_ROWS:      rows_ff <= csr_data[7:0];
               tep_pkg::IDX_COLS:      cols_ff <= csr_data[7:0];
               tep_pkg::IDX_DEF_ATTR:  def_ff <= csr_data;
               tep_pkg::IDX_REV_ATTR:  rev_ff <= csr_data;
               tep_pkg::IDX_KERN_ATTR: katt_ff <= csr_data;
               default: ;
            endcase
         end
         pstate_ff <= pstate_in;
         phase_ff <= phase_in;
         args_ff <= args_in;
         row_ff <= row_in;
         col_ff <= col_in;
         sd_ff <= sd_in;
         flags_ff <= flags_in;
         second_ff <= second_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hold_ld) hold_ff <= hold_cmd;
      if (emit) begin
         out_cmd_ff <= emit_cmd;
         out_crow_ff <= emit_cur ? row_ff : 8'd0;
         out_ccol_ff <= emit_cur ? col_ff : 8'd0;
         out_last_ff <= emit_cur;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_cmd = out_cmd_ff;
   assign rsp_cursor_row = out_crow_ff;
   assign rsp_cursor_col = out_ccol_ff;
   assign rsp_last = out_last_ff;

endmodule

FILE: rtl/tep_checker.sv
// ----------------------------------------------------------------------------
// tep_checker
// port-level checks of the command output
// ----------------------------------------------------------------------------
`include "text_terminal_escape_parser_macros.svh"

module tep_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_operation,
   input logic [7:0] rsp_cursor_row,
   input logic [7:0] rsp_cursor_col,
   input logic       rsp_last
);

   // a stalled word stays offered
   `TEP_ASSERT_NXT(a_hold_valid, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // the closing word of a byte is the cursor report
   `TEP_ASSERT_IMP(a_last_cursor, clock, reset, rsp_valid && rsp_last, rsp_operation == tep_pkg::OP_CURSOR)
   // a cursor report always closes its byte
   `TEP_ASSERT_IMP(a_cursor_last, clock, reset, rsp_valid && rsp_operation == tep_pkg::OP_CURSOR, rsp_last)
   // drawing words carry no cursor position
   `TEP_ASSERT_IMP(a_cursor_zero, clock, reset, rsp_valid && !rsp_last, rsp_cursor_row == 8'd0 && rsp_cursor_col == 8'd0)

endmodule

bind text_terminal_escape_parser tep_checker u_tep_checker (.*);

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// byte stream stimulus with a cycle-free predictor of the terminal parser;
// every command word is compared field by field against the predicted order
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] ch;
      logic       kern;
   } byte_word_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  row;
      logic [7:0]  col;
      logic [7:0]  src;
      logic [7:0]  dst;
      logic [7:0]  span;
      logic [7:0]  ch;
      logic [15:0] attr;
      logic [7:0]  crow;
      logic [7:0]  ccol;
      logic        last;
   } cmd_word_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_byte_in;
   logic        req_kernel_output;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_operation;
   logic [7:0]  rsp_row_index;
   logic [7:0]  rsp_col_index;
   logic [7:0]  rsp_source_index;
   logic [7:0]  rsp_dest_index;
   logic [7:0]  rsp_span_length;
   logic [7:0]  rsp_char_code;
   logic [15:0] rsp_attr_code;
   logic [7:0]  rsp_cursor_row;
   logic [7:0]  rsp_cursor_col;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   text_terminal_escape_parser dut (.*);

   // pending bytes for the driver, commands still owed by the parser
   byte_word_type pending_bytes[$];
   cmd_word_type  owed_cmds[$];

   // idle percentages, changed by the stimulus phases
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned hold_cycles;
   int unsigned mismatches;
   int unsigned quiet_cycles;
   bit          timed_out;

   // predictor copy of the terminal state
   logic [7:0]  m_rows, m_cols;
   logic [15:0] m_def_attr, m_rev_attr, m_kern_attr;
   tep_pkg::pstate_type m_pstate;
   logic [15:0] m_args[2];
   logic [7:0]  m_crow, m_ccol, m_scroll;
   logic [1:0]  m_rend;
   logic [15:0] m_cattr;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // ---------------------------------------------------------------- predictor
   function automatic int unsigned min_u(int unsigned a, int unsigned b);
      return a < b ? a : b;
   endfunction

   function automatic int unsigned eff_rows();
      return m_rows == 0 ? 1 : m_rows;
   endfunction

   function automatic int unsigned eff_cols();
      return m_cols == 0 ? 1 : m_cols;
   endfunction

   function automatic void owe(logic [2:0] op, int unsigned row, int unsigned col,
                               int unsigned src, int unsigned dst, int unsigned span,
                               int unsigned ch, int unsigned attr);
      cmd_word_type w;
      w = '0;
      w.op = op;
      w.row = row[7:0];
      w.col = col[7:0];
      w.src = src[7:0];
      w.dst = dst[7:0];
      w.span = span[7:0];
      w.ch = ch[7:0];
      w.attr = attr[15:0];
      owed_cmds.push_back(w);
   endfunction

   function automatic void reload_attr();
      m_cattr = (m_rend[tep_pkg::FLAG_INVERT] != m_rend[tep_pkg::FLAG_STANDOUT])
                ? m_rev_attr : m_def_attr;
   endfunction

   function automatic void line_feed();
      int unsigned r, d;
      r = eff_rows();
      if (m_crow < r - 1) begin
         m_crow++;
         return;
      end
      if (m_scroll == 0) begin
         // no scroll distance: wrap back to the top row
         m_crow = 0;
         owe(tep_pkg::OP_EROWS, 0, 0, 0, 0, 1, 0, m_cattr);
         return;
      end
      d = min_u(m_scroll, r);
      owe(tep_pkg::OP_CROWS, 0, 0, d, 0, r - d, 0, 0);
      owe(tep_pkg::OP_EROWS, r - d, 0, 0, 0, d, 0, m_cattr);
      m_crow = 8'(r - d);
   endfunction

   // normal-state handling, returns the next parse state
   function automatic tep_pkg::pstate_type plain_char(logic [7:0] c, bit kern);
      int unsigned cc, n, attr;
      cc = eff_cols();
      attr = kern ? m_kern_attr : m_cattr;
      case (c)
         tep_pkg::CH_BEL: begin
            owe(tep_pkg::OP_BELL, 0, 0, 0, 0, 0, 0, 0);
            return tep_pkg::ST_NORMAL;
         end
         tep_pkg::CH_BS: begin
            if (m_ccol > 0) m_ccol--;
            return tep_pkg::ST_NORMAL;
         end
         tep_pkg::CH_CR: begin
            m_ccol = 0;
            return tep_pkg::ST_NORMAL;
         end
         tep_pkg::CH_HT: begin
            n = min_u(8 - (m_ccol & 7), cc - m_ccol - 1);
            owe(tep_pkg::OP_ECOLS, m_crow, m_ccol, 0, 0, n, 0, attr);
            m_ccol = 8'(m_ccol + n);
            return tep_pkg::ST_NORMAL;
         end
         tep_pkg::CH_FF: begin
            owe(tep_pkg::OP_EROWS, 0, 0, 0, 0, eff_rows(), 0, attr);
            m_ccol = 0;
            m_crow = 0;
            return tep_pkg::ST_NORMAL;
         end
         tep_pkg::CH_VT: begin
            if (m_crow > 0) m_crow--;
            return tep_pkg::ST_NORMAL;
         end
         tep_pkg::CH_LF: begin
            line_feed();
            return tep_pkg::ST_NORMAL;
         end
         tep_pkg::CH_ESC: begin
            if (kern) return tep_pkg::ST_NORMAL;
            if (m_pstate == tep_pkg::ST_NORMAL) return tep_pkg::ST_ESC;
         end
         default: ;
      endcase
      owe(tep_pkg::OP_PUT, m_crow, m_ccol, 0, 0, 0, c, attr);
      if (m_ccol + 1 < cc) begin
         m_ccol++;
         return tep_pkg::ST_NORMAL;
      end
      m_ccol = 0;
      line_feed();
      return tep_pkg::ST_NORMAL;
   endfunction

   function automatic void final_byte(logic [7:0] c);
      int unsigned r, cc, a0, n0, n1, rl, cl, n;
      r = eff_rows();
      cc = eff_cols();
      a0 = m_args[0];
      n0 = m_args[0] != 0 ? m_args[0] : 1;
      n1 = m_args[1] != 0 ? m_args[1] : 1;
      rl = r - m_crow - 1;
      cl = cc - m_ccol - 1;
      case (c)
         tep_pkg::CH_ICH: begin
            n = min_u(n0, cl + 1);
            if (m_ccol + n < cc)
               owe(tep_pkg::OP_CCOLS, m_crow, 0, m_ccol, m_ccol + n, cc - m_ccol - n, 0, 0);
            owe(tep_pkg::OP_ECOLS, m_crow, m_ccol, 0, 0, n, 0, m_cattr);
         end
         tep_pkg::CH_CUU: m_crow = 8'(m_crow - min_u(n0, m_crow));
         tep_pkg::CH_CNL: begin
            m_ccol = 0;
            m_crow = 8'(m_crow + min_u(n0, rl));
         end
         tep_pkg::CH_CUD: m_crow = 8'(m_crow + min_u(n0, rl));
         tep_pkg::CH_CUF: m_ccol = 8'(m_ccol + min_u(n0, cl));
         tep_pkg::CH_CUB: m_ccol = 8'(m_ccol - min_u(n0, m_ccol));
         tep_pkg::CH_HVP, tep_pkg::CH_CUP: begin
            // arguments arrive row first, so the shifted one is the row
            m_crow = 8'(min_u(n1, r) - 1);
            m_ccol = 8'(min_u(n0, cc) - 1);
         end
         tep_pkg::CH_ED: begin
            if (rl > 0) owe(tep_pkg::OP_EROWS, m_crow + 1, 0, 0, 0, rl, 0, m_cattr);
            owe(tep_pkg::OP_ECOLS, m_crow, m_ccol, 0, 0, cl + 1, 0, m_cattr);
         end
         tep_pkg::CH_EL: owe(tep_pkg::OP_ECOLS, m_crow, m_ccol, 0, 0, cl + 1, 0, m_cattr);
         tep_pkg::CH_IL: begin
            n = min_u(n0, rl + 1);
            if (m_crow + n < r)
               owe(tep_pkg::OP_CROWS, 0, 0, m_crow, m_crow + n, r - m_crow - n, 0, 0);
            owe(tep_pkg::OP_EROWS, m_crow, 0, 0, 0, n, 0, m_cattr);
         end
         tep_pkg::CH_DL: begin
            n = min_u(n0, rl + 1);
            if (m_crow + n < r)
               owe(tep_pkg::OP_CROWS, 0, 0, m_crow + n, m_crow, r - m_crow - n, 0, 0);
            owe(tep_pkg::OP_EROWS, r - n, 0, 0, 0, n, 0, m_cattr);
         end
         tep_pkg::CH_DCH: begin
            n = min_u(n0, cl + 1);
            if (m_ccol + n < cc)
               owe(tep_pkg::OP_CCOLS, m_crow, 0, m_ccol + n, m_ccol, cc - m_ccol - n, 0, 0);
            owe(tep_pkg::OP_ECOLS, m_crow, cc - n, 0, 0, n, 0, m_cattr);
         end
         tep_pkg::CH_SGR: begin
            m_rend[tep_pkg::FLAG_STANDOUT] = (a0 != 0);
            reload_attr();
         end
         tep_pkg::CH_BOW: begin
            m_rend[tep_pkg::FLAG_INVERT] = 1'b1;
            reload_attr();
         end
         tep_pkg::CH_WOB: begin
            m_rend[tep_pkg::FLAG_INVERT] = 1'b0;
            reload_attr();
         end
         tep_pkg::CH_SCROLL: m_scroll = 8'(min_u(a0, r));
         tep_pkg::CH_RESET: begin
            m_scroll = 1;
            m_rend = '0;
            reload_attr();
         end
         default: ;
      endcase
   endfunction

   function automatic tep_pkg::pstate_type csi_char(logic [7:0] c);
      int unsigned v;
      if (c >= tep_pkg::CH_ZERO && c <= tep_pkg::CH_NINE) begin
         v = m_args[0] * 10 + (c - tep_pkg::CH_ZERO);
         m_args[0] = v > 65535 ? 16'hFFFF : v[15:0];
         return tep_pkg::ST_CSI;
      end
      if (c == tep_pkg::CH_SEMI) begin
         m_args[1] = m_args[0];
         m_args[0] = '0;
         return tep_pkg::ST_CSI;
      end
      final_byte(c);
      return tep_pkg::ST_NORMAL;
   endfunction

   // work out every command one byte owes, cursor report last
   function automatic void predict_byte(byte_word_type b);
      tep_pkg::pstate_type ns;
      cmd_word_type        w;
      if (m_crow >= eff_rows()) m_crow = 8'(eff_rows() - 1);
      if (m_ccol >= eff_cols()) m_ccol = 8'(eff_cols() - 1);
      if (b.kern) begin
         void'(plain_char(b.ch, 1'b1));
      end else begin
         if (m_pstate == tep_pkg::ST_ESC) begin
            if (b.ch == tep_pkg::CH_LBRACK) begin
               m_args[0] = '0;
               m_args[1] = '0;
               ns = tep_pkg::ST_CSI;
            end else begin
               void'(plain_char(tep_pkg::CH_ESC, 1'b0));
               ns = plain_char(b.ch, 1'b0);
            end
         end else if (m_pstate == tep_pkg::ST_CSI) begin
            ns = csi_char(b.ch);
         end else begin
            ns = plain_char(b.ch, 1'b0);
         end
         m_pstate = ns;
      end
      w = '0;
      w.op = tep_pkg::OP_CURSOR;
      w.crow = m_crow;
      w.ccol = m_ccol;
      w.last = 1'b1;
      owed_cmds.push_back(w);
   endfunction

   function automatic void model_csr(logic [2:0] idx, logic [15:0] val);
      case (idx)
         tep_pkg::IDX_ROWS: m_rows = val[7:0];
         tep_pkg::IDX_COLS: m_cols = val[7:0];
         tep_pkg::IDX_DEF_ATTR: begin
            m_def_attr = val;
            reload_attr();
         end
         tep_pkg::IDX_REV_ATTR: begin
            m_rev_attr = val;
            reload_attr();
         end
         tep_pkg::IDX_KERN_ATTR: m_kern_attr = val;
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- driver
   // prediction happens at acceptance so the state follows the accepted order
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_byte('{ch: req_byte_in, kern: req_kernel_output});
         end
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               byte_word_type nb;
               nb = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_byte_in <= nb.ch;
               req_kernel_output <= nb.kern;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         cmd_word_type got, exp_w;
         got = '{op: rsp_operation, row: rsp_row_index, col: rsp_col_index,
                 src: rsp_source_index, dst: rsp_dest_index, span: rsp_span_length,
                 ch: rsp_char_code, attr: rsp_attr_code, crow: rsp_cursor_row,
                 ccol: rsp_cursor_col, last: rsp_last};
         if (owed_cmds.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %p", got);
         end else begin
            exp_w = owed_cmds.pop_front();
            if (got !== exp_w) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word mismatch\n  expected %p\n  actual   %p", exp_w, got);
            end
         end
      end
   end

   // receiver ready, with a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready) || hold_cycles > 0)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic push_byte(logic [7:0] c, bit kern = 1'b0);
      pending_bytes.push_back('{ch: c, kern: kern});
   endtask

   task automatic push_csi(string args, logic [7:0] fin);
      push_byte(tep_pkg::CH_ESC);
      push_byte(tep_pkg::CH_LBRACK);
      foreach (args[i]) push_byte(args[i]);
      push_byte(fin);
   endtask

   task automatic drain();
      while (pending_bytes.size() > 0 || req_valid || owed_cmds.size() > 0)
         @(posedge clock);
      // no byte goes silent, but let the sequencer settle anyway
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      model_csr(idx, val);
   endtask

   // random item: a well-formed control sequence with random content, or a single random byte
   task automatic random_byte();
      logic [7:0] finals[17];
      int unsigned pick;
      int unsigned digits;
      finals = '{tep_pkg::CH_ICH, tep_pkg::CH_CUU, tep_pkg::CH_CUD, tep_pkg::CH_CUF,
                 tep_pkg::CH_CUB, tep_pkg::CH_CNL, tep_pkg::CH_CUP, tep_pkg::CH_ED,
                 tep_pkg::CH_EL, tep_pkg::CH_IL, tep_pkg::CH_DL, tep_pkg::CH_DCH,
                 tep_pkg::CH_HVP, tep_pkg::CH_SGR, tep_pkg::CH_BOW, tep_pkg::CH_WOB,
                 tep_pkg::CH_SCROLL};
      pick = $urandom_range(99);
      if (pick < 35) begin
         push_byte(tep_pkg::CH_ESC);
         push_byte(tep_pkg::CH_LBRACK);
         digits = $urandom_range(2);
         repeat (digits) push_byte(8'(tep_pkg::CH_ZERO + $urandom_range(9)));
         if ($urandom_range(2) == 0) begin
            push_byte(tep_pkg::CH_SEMI);
            digits = $urandom_range(2);
            repeat (digits) push_byte(8'(tep_pkg::CH_ZERO + $urandom_range(9)));
         end
         if ($urandom_range(9) == 0) push_byte(tep_pkg::CH_RESET);
         else push_byte(finals[$urandom_range(16)]);
      end else if (pick < 55) begin
         push_byte(8'($urandom_range(7, 13)), $urandom_range(3) == 0);
      end else if (pick < 65) begin
         push_byte(tep_pkg::CH_ESC, $urandom_range(3) == 0);
      end else begin
         push_byte(8'($urandom_range(255)), $urandom_range(4) == 0);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_byte_in = '0;
      req_kernel_output = 1'b0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = tep_pkg::IDX_ROWS;
      csr_data = '0;
      send_idle_pct = 30;
      recv_idle_pct = 54;
      hold_cycles = 0;
      mismatches = 0;
      quiet_cycles = 0;
      timed_out = 1'b0;
      m_rows = tep_pkg::ROWS_RST;
      m_cols = tep_pkg::COLS_RST;
      m_def_attr = tep_pkg::DEF_ATTR_RST;
      m_rev_attr = tep_pkg::REV_ATTR_RST;
      m_kern_attr = tep_pkg::KERN_ATTR_RST;
      m_pstate = tep_pkg::ST_NORMAL;
      m_args = '{default: '0};
      m_crow = 0;
      m_ccol = 0;
      m_scroll = 1;
      m_rend = '0;
      m_cattr = tep_pkg::DEF_ATTR_RST;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // small screen so wraps and scrolls come quickly
      write_csr(tep_pkg::IDX_ROWS, 16'd3);
      write_csr(tep_pkg::IDX_COLS, 16'd9);
      write_csr(tep_pkg::IDX_DEF_ATTR, 16'hA5A5);
      write_csr(tep_pkg::IDX_REV_ATTR, 16'h5A5A);
      write_csr(tep_pkg::IDX_KERN_ATTR, 16'hFFFF);

      // directed: control characters, extremes, wrap and empty tab span
      push_byte(tep_pkg::CH_BEL);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(tep_pkg::CH_HT);
      push_byte(tep_pkg::CH_HT);
      push_byte(tep_pkg::CH_BS);
      push_byte(tep_pkg::CH_CR);
      push_byte(tep_pkg::CH_VT);
      push_byte(tep_pkg::CH_FF, 1'b1);
      push_byte(tep_pkg::CH_ESC, 1'b1);
      push_byte(8'h41, 1'b1);
      push_byte(tep_pkg::CH_ESC);
      push_byte(tep_pkg::CH_ESC);
      push_csi("99999", tep_pkg::CH_SGR);
      push_csi("0", tep_pkg::CH_SCROLL);
      repeat (4) push_byte(tep_pkg::CH_LF);
      push_csi("3;2", tep_pkg::CH_CUP);
      push_csi("", tep_pkg::CH_IL);
      push_csi("9", tep_pkg::CH_DL);
      push_csi("", tep_pkg::CH_ICH);
      push_csi("", tep_pkg::CH_DCH);
      push_csi("", tep_pkg::CH_ED);
      push_csi("", 8'h7E);
      push_csi("", tep_pkg::CH_RESET);
      drain();

      // random, sender lazy, receiver lazier, long hold-off early on
      hold_cycles = 300;
      repeat (14) random_byte();
      drain();

      // extremes of geometry, zero acting as one
      write_csr(tep_pkg::IDX_ROWS, 16'd0);
      write_csr(tep_pkg::IDX_COLS, 16'd0);
      write_csr(tep_pkg::IDX_DEF_ATTR, 16'h0000);
      send_idle_pct = 54;
      recv_idle_pct = 30;
      repeat (10) random_byte();
      drain();

      write_csr(tep_pkg::IDX_ROWS, 16'd255);
      write_csr(tep_pkg::IDX_COLS, 16'd255);
      write_csr(tep_pkg::IDX_REV_ATTR, 16'hFFFF);
      write_csr(tep_pkg::IDX_KERN_ATTR, 16'h0000);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (8) random_byte();
      drain();

      // cursor clamp after shrinking the screen
      write_csr(tep_pkg::IDX_ROWS, 16'd5);
      write_csr(tep_pkg::IDX_COLS, 16'd12);
      repeat (8) random_byte();
      drain();

      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/tep_pkg.sv
rtl/tep_front.sv
rtl/tep_exec.sv
rtl/text_terminal_escape_parser.sv
rtl/tep_checker.sv
tb/sv/testbench.sv
